// ===== design/can_bit_correlation_counter_core_macros.svh =====
// assertion macros for the correlation counter checker
`ifndef CAN_BIT_CORRELATION_COUNTER_CORE_MACROS_SVH
`define CAN_BIT_CORRELATION_COUNTER_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define CBCC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbcc assertion failed");

// next-cycle implication, quiet during reset
`define CBCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbcc assertion failed");

`endif

// ===== design/cbcc_pkg.sv =====
package cbcc_pkg;

  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 32;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_BUS   = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_ADDRESS  = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_BYTE     = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_BIT      = 8'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEARCH_BUS   = 8'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_EQUAL_MODE   = 8'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_MINIMUM      = 8'd6;

  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [7:0]  source_bus;
    logic [10:0] reference_address;
    logic [2:0]  reference_byte;
    logic [2:0]  reference_bit;
    logic [7:0]  search_bus;
    logic        equal_mode;
    logic [23:0] minimum_count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HDR_RD,
    ST_HDR_WR,
    ST_ROW_RD,
    ST_ROW_WR,
    ST_REP_RD,
    ST_EMIT
  } state_t;

endpackage

// ===== design/cbcc_if.sv =====
interface cbcc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  bus;
  logic [10:0] frame_address;
  logic [3:0]  length;
  logic [63:0] payload;
  logic [2:0]  report_byte;
  modport source(output valid, kind, bus, frame_address, length, payload, report_byte,
                 input ready);
  modport sink(input valid, kind, bus, frame_address, length, payload, report_byte,
               output ready);
endinterface

interface cbcc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_index;
  logic [2:0]  bit_index;
  logic [23:0] mismatches;
  logic [23:0] total;
  logic        qualifies;
  logic        last;
  modport source(output valid, byte_index, bit_index, mismatches, total, qualifies, last,
                 input ready);
  modport sink(input valid, byte_index, bit_index, mismatches, total, qualifies, last,
               output ready);
endinterface

interface cbcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/cbcc_ram.sv =====
module cbcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== design/cbcc_cfg.sv =====
module cbcc_cfg (
  input  logic          clk,
  input  logic          rst_n,
  cbcc_cfg_if.sink      cfg_chan,
  output cbcc_pkg::cfg_t cfg
);
  import cbcc_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_SOURCE_BUS:  cfg_nxt.source_bus        = cfg_chan.data[7:0];
        REG_REF_ADDRESS: cfg_nxt.reference_address = cfg_chan.data[10:0];
        REG_REF_BYTE:    cfg_nxt.reference_byte    = cfg_chan.data[2:0];
        REG_REF_BIT:     cfg_nxt.reference_bit     = cfg_chan.data[2:0];
        REG_SEARCH_BUS:  cfg_nxt.search_bus        = cfg_chan.data[7:0];
        REG_EQUAL_MODE:  cfg_nxt.equal_mode        = cfg_chan.data[0];
        REG_MINIMUM:     cfg_nxt.minimum_count     = cfg_chan.data[23:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{source_bus: 8'd0, reference_address: 11'd0, reference_byte: 3'd0,
                 reference_bit: 3'd0, search_bus: 8'd0, equal_mode: 1'b1,
                 minimum_count: 24'd100};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule

// ===== design/can_bit_correlation_counter_core.sv =====
// CAN bit correlation counter. Frame items on the configured search bus bump a
// per-address frame total and, once the reference bit has been seen on the
// source bus, one saturating counter per payload bit that differs from (equal
// mode) or matches the reference. A report item returns eight results, one per
// bit of the asked byte, with a qualifies flag. State lives in two RAMs: a
// header RAM (total, tracked length, tracked flag) per address and a counter
// RAM with one row of eight counters per address and byte. After reset a
// clearing pass zeroes every row of both RAMs, during which no item is taken.
// Per item: a frame off the search bus ends at accept; a search frame reads
// then writes back its header, then each data byte's counter row (read then
// write back through the single RAM port pair), or only its header while the
// reference is unknown; a report reads header and row, then offers 8 results.
module can_bit_correlation_counter_core #(
  parameter int ADDR_BITS  = 11,
  parameter int MAX_BYTES  = 8,
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  cbcc_in_if.sink     in_chan,
  cbcc_out_if.source  out_chan,
  cbcc_cfg_if.sink    cfg_chan
);
  import cbcc_pkg::*;

  localparam int NUM_ADDR = 1 << ADDR_BITS;
  localparam int DEPTH    = NUM_ADDR * MAX_BYTES;
  localparam int ROW_BITS = $clog2(DEPTH);
  localparam int HDR_W    = COUNT_BITS + 5;
  localparam int ROW_W    = 8 * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  cfg_t cfg;

  cbcc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  state_t state_r, state_nxt;

  // clearing pass counter
  logic [ROW_BITS-1:0] clr_r;

  // latched item
  logic [ADDR_BITS-1:0] addr_r;
  logic [3:0]           len_r;
  logic [63:0]          payload_r;
  logic [2:0]           rbyte_r;
  logic [3:0]           byte_r;
  logic [2:0]           bit_r;

  // reference bit
  logic ref_known_r, ref_value_r;

  // ram ports
  logic                hdr_we, hdr_re, row_we, row_re;
  logic [ADDR_BITS-1:0] hdr_waddr, hdr_raddr;
  logic [HDR_W-1:0]    hdr_wdata, hdr_rdata;
  logic [ROW_BITS-1:0] row_waddr, row_raddr;
  logic [ROW_W-1:0]    row_wdata, row_rdata;

  cbcc_ram #(.WIDTH(HDR_W), .DEPTH(NUM_ADDR)) u_hdr_ram (
    .clk(clk), .we(hdr_we), .waddr(hdr_waddr), .wdata(hdr_wdata),
    .re(hdr_re), .raddr(hdr_raddr), .rdata(hdr_rdata)
  );

  cbcc_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .re(row_re), .raddr(row_raddr), .rdata(row_rdata)
  );

  // incoming frame decode
  logic [3:0] in_len_c;
  logic       in_accept;
  logic       ref_hit_c;
  logic [7:0] ref_src_byte;

  assign in_accept = in_chan.valid && in_chan.ready;
  assign in_len_c  = (in_chan.length > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : in_chan.length;
  assign ref_hit_c = (in_chan.kind == KIND_FRAME) && (in_chan.bus == cfg.source_bus) &&
                     (in_chan.frame_address == cfg.reference_address) &&
                     (in_len_c > {1'b0, cfg.reference_byte});
  assign ref_src_byte = in_chan.payload[8 * (7 - int'(cfg.reference_byte)) +: 8];

  // header fields
  logic [COUNT_BITS-1:0] hdr_total;
  logic [3:0]            hdr_len;
  logic                  hdr_flag;
  logic [COUNT_BITS-1:0] total_inc;
  assign {hdr_flag, hdr_len, hdr_total} = hdr_rdata;
  assign total_inc = (hdr_total == CMAX) ? CMAX : hdr_total + 1'b1;

  // row index of (address, byte)
  function automatic logic [ROW_BITS-1:0] row_of(input logic [ADDR_BITS-1:0] a,
                                                 input logic [3:0] b);
    return ROW_BITS'(int'(a) * MAX_BYTES + int'(b));
  endfunction

  // counter row update for the byte under work
  logic [7:0] work_byte;
  assign work_byte = payload_r[8 * (7 - int'(byte_r[2:0])) +: 8];

  always_comb begin
    logic [COUNT_BITS-1:0] c;
    logic                  b;
    logic                  hit;
    row_wdata = '0;
    for (int j = 0; j < 8; j++) begin
      c   = row_rdata[j * COUNT_BITS +: COUNT_BITS];
      b   = work_byte[7 - j];
      hit = cfg.equal_mode ? (b != ref_value_r) : (b == ref_value_r);
      if (hit && c != CMAX) begin
        c = c + 1'b1;
      end
      row_wdata[j * COUNT_BITS +: COUNT_BITS] = c;
    end
    if (state_r == ST_CLEAR) begin
      row_wdata = '0;
    end
  end

  // sequencer: each entry is read, then written back before the next read,
  // so no access overlaps another to the same entry
  always_comb begin
    state_nxt = state_r;
    hdr_we    = 1'b0;
    hdr_re    = 1'b0;
    row_we    = 1'b0;
    row_re    = 1'b0;
    hdr_waddr = addr_r;
    hdr_raddr = addr_r;
    hdr_wdata = {1'b1, hdr_len, total_inc};
    row_waddr = row_of(addr_r, byte_r);
    row_raddr = row_of(addr_r, byte_r);
    case (state_r)
      ST_CLEAR: begin
        hdr_we    = 1'b1;
        row_we    = 1'b1;
        hdr_waddr = clr_r[ADDR_BITS-1:0];
        row_waddr = clr_r;
        hdr_wdata = '0;
        if (clr_r == ROW_BITS'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (in_chan.kind == KIND_REPORT) begin
            state_nxt = ST_REP_RD;
          end else if (in_chan.bus == cfg.search_bus) begin
            state_nxt = ST_HDR_RD;
          end
        end
      end
      ST_HDR_RD: begin
        hdr_re    = 1'b1;
        state_nxt = ST_HDR_WR;
      end
      ST_HDR_WR: begin
        hdr_we = 1'b1;
        if (ref_known_r) begin
          hdr_wdata = {1'b1, (len_r > hdr_len) ? len_r : hdr_len, total_inc};
        end else begin
          hdr_wdata = {hdr_flag, hdr_len, total_inc};
        end
        state_nxt = (ref_known_r && len_r != 4'd0) ? ST_ROW_RD : ST_IDLE;
      end
      ST_ROW_RD: begin
        row_re    = 1'b1;
        state_nxt = ST_ROW_WR;
      end
      ST_ROW_WR: begin
        row_we    = 1'b1;
        state_nxt = (byte_r + 4'd1 < len_r) ? ST_ROW_RD : ST_IDLE;
      end
      ST_REP_RD: begin
        hdr_re    = 1'b1;
        row_re    = ({1'b0, rbyte_r} < 4'(MAX_BYTES));
        row_raddr = row_of(addr_r, {1'b0, rbyte_r});
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_chan.ready && bit_r == 3'd7) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      ref_known_r <= 1'b0;
      ref_value_r <= 1'b0;
      byte_r      <= '0;
      bit_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      // reference is taken at accept, ahead of counting the same frame
      if (in_accept && ref_hit_c) begin
        ref_known_r <= 1'b1;
        ref_value_r <= ref_src_byte[7 - int'(cfg.reference_bit)];
      end
      if (in_accept) begin
        byte_r <= '0;
        bit_r  <= '0;
      end
      if (state_r == ST_ROW_WR) begin
        byte_r <= byte_r + 4'd1;
      end
      if (state_r == ST_EMIT && out_chan.ready) begin
        bit_r <= bit_r + 3'd1;
      end
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      addr_r    <= ADDR_BITS'(in_chan.frame_address);
      len_r     <= in_len_c;
      payload_r <= in_chan.payload;
      rbyte_r   <= in_chan.report_byte;
    end
  end

  // report results, straight off the registered ram outputs
  logic                  byte_ok;
  logic [COUNT_BITS-1:0] mis_c;
  assign byte_ok = ({1'b0, rbyte_r} < 4'(MAX_BYTES));
  assign mis_c   = byte_ok ? row_rdata[int'(bit_r) * COUNT_BITS +: COUNT_BITS] : '0;

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign out_chan.valid      = (state_r == ST_EMIT);
  assign out_chan.byte_index = rbyte_r;
  assign out_chan.bit_index  = bit_r;
  assign out_chan.mismatches = 24'(mis_c);
  assign out_chan.total      = 24'(hdr_total);
  assign out_chan.last       = (bit_r == 3'd7);
  assign out_chan.qualifies  = hdr_flag && byte_ok && ({1'b0, rbyte_r} < hdr_len) &&
                               (33'(hdr_total) > 33'(cfg.minimum_count)) &&
                               ({mis_c, 1'b0} < {1'b0, hdr_total});
endmodule

// ===== design/cbcc_checker.sv =====
`include "can_bit_correlation_counter_core_macros.svh"

module cbcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_last,
  input logic [2:0] out_bit_index
);
  // bit index the following result must carry
  logic [2:0] next_bit;
  assign next_bit = out_bit_index + 3'd1;

  // results of a report leave before the next item enters
  `CBCC_ASSERT_IMPL(a_no_input_during_report, out_valid, !in_ready)
  // stalled result stays offered
  `CBCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // results come in bit order without gaps
  `CBCC_ASSERT_NEXT(a_bit_order, out_valid && out_ready && !out_last, out_bit_index == $past(next_bit))
  // a report ends with its last result
  `CBCC_ASSERT_NEXT(a_end_after_last, out_valid && out_ready && out_last, !out_valid)
endmodule

bind can_bit_correlation_counter_core cbcc_checker u_cbcc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_last      (out_chan.last),
  .out_bit_index (out_chan.bit_index)
);
